// ===== design/seven_segment_clock_display_macros.svh =====
// -----------------------------------------------------------------------------
// seven_segment_clock_display_macros - assertion helpers
// Concurrent assertion shorthands clocked on clock, disabled during reset.
// -----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_CLOCK_DISPLAY_MACROS_SVH
`define SEVEN_SEGMENT_CLOCK_DISPLAY_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SSCD_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define SSCD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/sscd_pkg.sv =====
// -----------------------------------------------------------------------------
// sscd_pkg - shared types and constants
// Transaction structs, op codes, digit decode and fixed arithmetic constants.
// -----------------------------------------------------------------------------
package sscd_pkg;

   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_CLEAR   = 2'd1;
   localparam logic [1:0] OP_REFRESH = 2'd2;

   localparam int          QUEUE_DEPTH = 4;
   localparam int          PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int          CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [5:0]  SECOND_LAST = 6'd59;
   localparam logic [11:0] MV_FULL     = 12'd3300;
   localparam logic [16:0] ADC_FULL    = 17'd65535;
   // floor(x/10) = (x*6554)>>16 for x < 16384, (x*205)>>11 for x < 1029
   localparam logic [12:0] RECIP_16    = 13'd6554;
   localparam logic [7:0]  RECIP_11    = 8'd205;

   localparam logic [1:0]  DP_VOLT     = 2'd0;
   localparam logic [1:0]  DP_CLOCK    = 2'd1;
   localparam logic [1:0]  LAST_FRAME  = 2'd3;
   localparam int          DP_BIT      = 7;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] adc_sample;
      logic        show_voltage;
   } req_type;

   typedef struct packed {
      logic [7:0] segments;
      logic [3:0] digit_select;
      logic       last;
   } rsp_type;

   // decoded refresh: digit[0] is leftmost
   typedef struct packed {
      logic [3:0][3:0] digit;
      logic [1:0]      dp_pos;
   } entry_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } q_status_type;

   // lit-high segment pattern, g..a in bits 6..0
   function automatic logic [6:0] seg_lit(input logic [3:0] d);
      logic [6:0] s;
      unique case (d)
         4'd0: s = 7'h3F;
         4'd1: s = 7'h06;
         4'd2: s = 7'h5B;
         4'd3: s = 7'h4F;
         4'd4: s = 7'h66;
         4'd5: s = 7'h6D;
         4'd6: s = 7'h7D;
         4'd7: s = 7'h07;
         4'd8: s = 7'h7F;
         4'd9: s = 7'h6F;
         default: s = 7'h00;
      endcase
      return s;
   endfunction

endpackage

// ===== design/sscd_front.sv =====
// -----------------------------------------------------------------------------
// sscd_front - transaction intake and refresh decode
// Keeps the MM:SS counters and turns each refresh into four decimal digits.
// -----------------------------------------------------------------------------
module sscd_front #(
   parameter int MINUTE_WRAP = 100
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sscd_pkg::req_type   req_data,
   input  logic                credit_return,
   output logic                push_valid,
   output sscd_pkg::entry_type push_entry
);

   logic                        accept;
   logic                        take_refresh;
   logic [5:0]                  second_ff, second_in;
   logic [6:0]                  minute_ff, minute_in;
   logic [sscd_pkg::CNT_W-1:0]  used_ff, used_in;

   // stage 1: raw operands
   logic        v1_ff;
   logic        volt1_ff;
   logic [27:0] prod1_ff;
   logic [6:0]  minute1_ff;
   logic [5:0]  second1_ff;
   // stage 2: display value 0..9999
   logic        v2_ff;
   logic [1:0]  dp2_ff;
   logic [13:0] value2_ff;
   logic [11:0] q0;
   logic [16:0] rem0;
   logic [13:0] mv;
   logic [13:0] mmss;
   // stage 3
   logic        v3_ff;
   logic [1:0]  dp3_ff;
   logic [9:0]  q1_ff;
   logic [3:0]  d3_3_ff;
   logic [26:0] p3;
   // stage 4
   logic        v4_ff;
   logic [1:0]  dp4_ff;
   logic [6:0]  q2_ff;
   logic [3:0]  d2_4_ff, d3_4_ff;
   logic [17:0] p4;
   logic [14:0] p5;
   logic [3:0]  q3;

   assign req_ready    = used_ff < sscd_pkg::CNT_W'(sscd_pkg::QUEUE_DEPTH);
   assign accept       = req_valid && req_ready;
   assign take_refresh = accept && (req_data.op == sscd_pkg::OP_REFRESH);

   always_comb begin
      second_in = second_ff;
      minute_in = minute_ff;
      if (accept) begin
         unique case (req_data.op)
            sscd_pkg::OP_TICK: begin
               if (second_ff == sscd_pkg::SECOND_LAST) begin
                  second_in = 6'd0;
                  if (minute_ff == 7'(MINUTE_WRAP - 1)) minute_in = 7'd0;
                  else minute_in = minute_ff + 7'd1;
               end else begin
                  second_in = second_ff + 6'd1;
               end
            end
            sscd_pkg::OP_CLEAR: begin
               second_in = 6'd0;
               minute_in = 7'd0;
            end
            default: ;
         endcase
      end
      used_in = used_ff + sscd_pkg::CNT_W'(take_refresh)
                        - sscd_pkg::CNT_W'(credit_return);
   end

   // x/65535 for x < 2^28: quotient is x>>16 plus one correction step
   always_comb begin
      q0   = prod1_ff[27:16];
      rem0 = 17'(prod1_ff[15:0]) + 17'(q0);
      mv   = 14'(q0) + ((rem0 >= sscd_pkg::ADC_FULL) ? 14'd1 : 14'd0);
      mmss = 14'(minute1_ff) * 14'd100 + 14'(second1_ff);
      p3   = 27'(value2_ff) * 27'(sscd_pkg::RECIP_16);
      p4   = 18'(q1_ff) * 18'(sscd_pkg::RECIP_11);
      p5   = 15'(q2_ff) * 15'(sscd_pkg::RECIP_11);
      q3   = p5[14:11];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff <= '0;
         minute_ff <= '0;
         used_ff   <= '0;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         v4_ff     <= 1'b0;
      end else begin
         second_ff <= second_in;
         minute_ff <= minute_in;
         used_ff   <= used_in;
         v1_ff     <= take_refresh;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         v4_ff     <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      volt1_ff   <= req_data.show_voltage;
      prod1_ff   <= 28'(req_data.adc_sample) * 28'(sscd_pkg::MV_FULL);
      minute1_ff <= minute_ff;
      second1_ff <= second_ff;

      dp2_ff    <= volt1_ff ? sscd_pkg::DP_VOLT : sscd_pkg::DP_CLOCK;
      value2_ff <= volt1_ff ? mv : mmss;

      dp3_ff  <= dp2_ff;
      q1_ff   <= p3[25:16];
      d3_3_ff <= 4'(value2_ff - 14'(p3[25:16]) * 14'd10);

      dp4_ff  <= dp3_ff;
      q2_ff   <= p4[17:11];
      d2_4_ff <= 4'(q1_ff - 10'(p4[17:11]) * 10'd10);
      d3_4_ff <= d3_3_ff;
   end

   assign push_valid          = v4_ff;
   assign push_entry.dp_pos   = dp4_ff;
   assign push_entry.digit[0] = q3;
   assign push_entry.digit[1] = 4'(q2_ff - 7'(q3) * 7'd10);
   assign push_entry.digit[2] = d2_4_ff;
   assign push_entry.digit[3] = d3_4_ff;

endmodule

// ===== design/sscd_queue.sv =====
// -----------------------------------------------------------------------------
// sscd_queue - refresh queue
// Small FIFO of decoded refreshes between the front and back ends.
// -----------------------------------------------------------------------------
module sscd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  sscd_pkg::entry_type    push_entry,
   input  logic                   pop,
   output sscd_pkg::entry_type    head,
   output sscd_pkg::q_status_type status
);

   sscd_pkg::entry_type          mem [sscd_pkg::QUEUE_DEPTH];
   logic [sscd_pkg::PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [sscd_pkg::CNT_W-1:0]   count_ff;

   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + sscd_pkg::CNT_W'(push) - sscd_pkg::CNT_W'(pop);
      end
   end

   assign head             = mem[rd_ptr_ff];
   assign status.not_empty = count_ff != '0;
   assign status.full      = count_ff == sscd_pkg::CNT_W'(sscd_pkg::QUEUE_DEPTH);

endmodule

// ===== design/sscd_back.sv =====
// -----------------------------------------------------------------------------
// sscd_back - frame generator
// Walks the four digits of a queued refresh, one registered frame per cycle while rsp_ready allows.
// -----------------------------------------------------------------------------
module sscd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  sscd_pkg::entry_type head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output sscd_pkg::rsp_type   rsp_data
);

   logic [1:0]         idx_ff;
   logic               rsp_valid_ff;
   sscd_pkg::rsp_type  rsp_data_ff, frame;
   logic               load;

   assign load = q_valid && (!rsp_valid_ff || rsp_ready);
   assign pop  = load && (idx_ff == sscd_pkg::LAST_FRAME);

   always_comb begin
      frame.segments     = {1'b1, ~sscd_pkg::seg_lit(head.digit[idx_ff])};
      if (idx_ff == head.dp_pos) frame.segments[sscd_pkg::DP_BIT] = 1'b0;
      frame.digit_select = 4'b0001 << idx_ff;
      frame.last         = idx_ff == sscd_pkg::LAST_FRAME;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            idx_ff       <= idx_ff + 2'd1;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) rsp_data_ff <= frame;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/seven_segment_clock_display.sv =====
// -----------------------------------------------------------------------------
// seven_segment_clock_display - MM:SS clock with 4-digit display frames
// Tick / clear / refresh transactions in, active-low display frames out.
// -----------------------------------------------------------------------------
// Usage:
//   req_* channel: one transaction per accepted cycle. op tick advances the
//   clock one second (seconds wrap at 60, minutes at MINUTE_WRAP), op clear
//   zeroes it, op refresh produces four display frames; op code 3 is dropped.
//   rsp_* channel: frames, leftmost digit first, last set on the fourth.
//   Refresh shows MMSS (decimal point on digit 1) or, with show_voltage,
//   floor(adc_sample*3300/65535) millivolts (decimal point on digit 0).
// Path: the first frame of a refresh passes the decode pipe, the queue and the
//   output register; the other three follow on consecutive cycles when rsp_ready stays high.
// Throughput: ticks and clears go at one per cycle while req_ready is high. Refreshes
//   are limited by the frame generator emitting one frame per cycle when not stalled.
// Stall: a held rsp_ready freezes the current frame. Up to 4 refreshes
//   (in the decode pipe or queued) are absorbed, after which req_ready drops.
// Reset: clock goes to 00:00, pipe and queue empty, no frame valid.
// -----------------------------------------------------------------------------
`include "seven_segment_clock_display_macros.svh"

module seven_segment_clock_display #(
   parameter int MINUTE_WRAP = 100
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sscd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sscd_pkg::rsp_type rsp_data
);

   // front -> queue
   logic                   push_valid;
   sscd_pkg::entry_type    push_entry;
   // queue -> back
   sscd_pkg::entry_type    head;
   sscd_pkg::q_status_type q_status;
   logic                   pop;

   // front: clock counters plus refresh decode; credits come back on pop
   sscd_front #(
      .MINUTE_WRAP(MINUTE_WRAP)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .credit_return(pop),
      .push_valid   (push_valid),
      .push_entry   (push_entry)
   );

   sscd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_entry(push_entry),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   // back: one frame per cycle into the output register while rsp_ready allows
   sscd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_status.not_empty),
      .head     (head),
      .pop      (pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // credit scheme must keep the queue from overflowing
   `SSCD_ASSERT_SAME(a_no_overflow, push_valid && !pop, !q_status.full, "queue overflow")
   // pop only a present entry
   `SSCD_ASSERT_SAME(a_pop_nonempty, pop, q_status.not_empty, "pop of empty queue")
   // retiring an entry means its fourth frame is what goes out next
   `SSCD_ASSERT_NEXT(a_pop_last, pop, rsp_valid && rsp_data.last, "pop without last frame")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_top - testbench for seven_segment_clock_display
// Drives tick, clear, refresh and unused-op transactions with random idling
// and one long result stall. A local copy of the MM:SS clock renders the four
// display frames that each refresh is due to produce, and every frame that
// leaves the block is compared field by field against the oldest one pending.
// -----------------------------------------------------------------------------
module tb_top;

   // op code 3 has no meaning; the block must drop it
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int MINUTE_WRAP    = 100;
   localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transaction
   localparam int HOLD_CYCLES    = 80;    // long receiver stall
   localparam int DRAIN_CYCLES   = 16;    // quiet time after the last frame
   localparam int RANDOM_ITEMS   = 36;
   localparam int IDLE_PCT       = 37;

   // lit-high patterns, g..a in bits 6..0, glyph for digit d at index d
   localparam logic [9:0][6:0] DIGIT_GLYPH = {
      7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   sscd_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   sscd_pkg::rsp_type rsp_data;

   // receiver controls; hold_arm and rx_steady are written with nonblocking assignments by the tests
   logic    hold_arm = 1'b0;
   logic    rx_steady = 1'b0;
   int      hold_cnt = 0;

   // sender control, used only by the stimulus process
   bit      tx_idle = 1'b1;

   // predicted clock state and the frames still owed by the block
   logic [5:0]        sec_count = '0;
   logic [6:0]        min_count = '0;
   sscd_pkg::rsp_type pending_frames[$];
   int                mismatch_count = 0;
   int                quiet_cycles = 0;

   seven_segment_clock_display #(
      .MINUTE_WRAP(MINUTE_WRAP)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Prediction: update the clock on tick/clear, render four frames on refresh.
   // Unused op codes leave everything alone.
   // ---------------------------------------------------------------------------
   function automatic void render_request(input sscd_pkg::req_type r);
      int unsigned       value;
      int unsigned       digit [4];
      logic [1:0]        dp_pos;
      sscd_pkg::rsp_type frame;
      int                i;
      case (r.op)
         sscd_pkg::OP_TICK: begin
            if (sec_count == 6'd59) begin
               sec_count = '0;
               if (min_count == 7'(MINUTE_WRAP - 1)) min_count = '0;
               else min_count = min_count + 7'd1;
            end else begin
               sec_count = sec_count + 6'd1;
            end
         end
         sscd_pkg::OP_CLEAR: begin
            sec_count = '0;
            min_count = '0;
         end
         sscd_pkg::OP_REFRESH: begin
            if (r.show_voltage) begin
               // millivolts, exact integer floor of adc * 3300 / 65535
               value  = (32'(r.adc_sample) * 32'd3300) / 32'd65535;
               dp_pos = 2'd0;
            end else begin
               value  = int'(min_count) * 100 + int'(sec_count);
               dp_pos = 2'd1;
            end
            digit[0] = (value / 1000) % 10;
            digit[1] = (value / 100) % 10;
            digit[2] = (value / 10) % 10;
            digit[3] = value % 10;
            for (i = 0; i < 4; i++) begin
               frame.segments     = ~{1'b0, DIGIT_GLYPH[digit[i]]};
               if (i == int'(dp_pos)) frame.segments[7] = 1'b0;
               frame.digit_select = 4'b0001 << i;
               frame.last         = (i == 3);
               pending_frames.push_back(frame);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void check_frame(input sscd_pkg::rsp_type got);
      sscd_pkg::rsp_type want;
      if (pending_frames.size() == 0) begin
         $error("frame with nothing pending: segments=%h digit_select=%h last=%b",
                got.segments, got.digit_select, got.last);
         mismatch_count++;
      end else begin
         want = pending_frames.pop_front();
         if (got.segments !== want.segments) begin
            $error("segments: expected %h, got %h", want.segments, got.segments);
            mismatch_count++;
         end
         if (got.digit_select !== want.digit_select) begin
            $error("digit_select: expected %h, got %h",
                   want.digit_select, got.digit_select);
            mismatch_count++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, got.last);
            mismatch_count++;
         end
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Monitor: samples both channels at the edge, predicts accepted requests,
   // checks accepted frames, and ends the run if traffic stops.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_valid && req_ready) render_request(req_data);
         if (rsp_valid && rsp_ready) check_frame(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Receiver: one armed long stall, otherwise steady or randomly idle.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_cnt  <= 0;
      end else if (hold_arm && hold_cnt < HOLD_CYCLES) begin
         rsp_ready <= 1'b0;
         hold_cnt  <= hold_cnt + 1;
      end else if (rx_steady) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // ---------------------------------------------------------------------------
   // Sender: offer one transaction, hold it until taken, then maybe go idle.
   // Valid stays high into the next call when no idle gap is drawn.
   // ---------------------------------------------------------------------------
   task automatic send_item(input logic [1:0] op, input logic [15:0] adc,
                            input logic volt);
      sscd_pkg::req_type item;
      int                gap;
      item.op           = op;
      item.adc_sample   = adc;
      item.show_voltage = volt;
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      gap = 0;
      if (tx_idle) while ($urandom_range(99) < IDLE_PCT) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // ticks carry random payload, which must not matter
   task automatic tick_n(input int n);
      repeat (n) send_item(sscd_pkg::OP_TICK, 16'($urandom), 1'($urandom));
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // clock at 00:00 and the converter extremes
   task automatic test_refresh_extremes;
      send_item(sscd_pkg::OP_REFRESH, 16'hFFFF, 1'b0);   // 00.00, adc ignored
      send_item(sscd_pkg::OP_REFRESH, 16'h0000, 1'b1);   // 0 mV
      send_item(sscd_pkg::OP_REFRESH, 16'hFFFF, 1'b1);   // 3300 mV full scale
      send_item(sscd_pkg::OP_REFRESH, 16'hFFFE, 1'b1);   // 3299, floor just below
      send_item(sscd_pkg::OP_REFRESH, 16'h0001, 1'b1);   // rounds down to 0
      send_item(sscd_pkg::OP_REFRESH, 16'd20, 1'b1);     // first code giving 1 mV
      send_item(sscd_pkg::OP_REFRESH, 16'h8000, 1'b1);   // mid scale
      send_item(sscd_pkg::OP_REFRESH, 16'h5555, 1'b1);
   endtask

   // seconds carry into minutes
   task automatic test_clock_rollover;
      send_item(sscd_pkg::OP_CLEAR, 16'hA5A5, 1'b1);
      tick_n(59);
      send_item(sscd_pkg::OP_REFRESH, 16'h0000, 1'b0);   // 00:59
      tick_n(1);
      send_item(sscd_pkg::OP_REFRESH, 16'hFFFF, 1'b0);   // 01:00
   endtask

   // unused op code is dropped; clear zeroes a running clock
   task automatic test_clear_and_unused;
      tick_n(5);
      send_item(OP_UNUSED, 16'hFFFF, 1'b1);
      send_item(OP_UNUSED, 16'h0000, 1'b0);
      send_item(sscd_pkg::OP_REFRESH, 16'h1234, 1'b0);   // 01:05 still
      send_item(sscd_pkg::OP_CLEAR, 16'hFFFF, 1'b0);
      send_item(sscd_pkg::OP_REFRESH, 16'h0000, 1'b0);
   endtask

   // receiver stalls long while refreshes keep coming, filling the block
   task automatic test_backpressure;
      tx_idle = 1'b0;
      hold_arm <= 1'b1;
      repeat (12) send_item(sscd_pkg::OP_REFRESH, 16'($urandom), 1'($urandom));
      tx_idle = 1'b1;
   endtask

   // random mix of all op codes
   task automatic test_random_mix;
      int pick;
      int k;
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         // middle third runs with no idling on either side
         if (k == RANDOM_ITEMS / 3) begin
            tx_idle = 1'b0;
            rx_steady <= 1'b1;
         end else if (k == 2 * RANDOM_ITEMS / 3) begin
            tx_idle = 1'b1;
            rx_steady <= 1'b0;
         end
         pick = $urandom_range(99);
         if (pick < 45) begin
            send_item(sscd_pkg::OP_REFRESH, 16'($urandom), 1'($urandom));
         end else if (pick < 80) begin
            tick_n(1);
         end else if (pick < 90) begin
            send_item(sscd_pkg::OP_CLEAR, 16'($urandom), 1'($urandom));
         end else begin
            send_item(OP_UNUSED, 16'($urandom), 1'($urandom));
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_refresh_extremes();
      test_clock_rollover();
      test_clear_and_unused();
      test_backpressure();
      test_random_mix();

      req_valid <= 1'b0;
      // all frames must come back; the watchdog covers a hang here
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
